### rtl/set_assoc_cache_tag_lookup_unit_assert.svh
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_unit_assert
// assertion macros for the tag lookup unit
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_UNIT_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_UNIT_ASSERT_SVH

// implication checked on every rising edge outside reset
`define SACT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// a signal holds its value on the edge after the condition
`define SACT_STABLE(label, cond, sig, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        cond |=> $stable(sig)) else $error(msg);

`endif

### rtl/sactl_pkg.sv
// ----------------------------------------------------------------------------
// sactl_pkg
// shared constants and types of the set-associative tag lookup unit
// ----------------------------------------------------------------------------
package sactl_pkg;

    localparam int MaxSetBits = 8;
    localparam int Ways       = 8;
    localparam int SetCount   = 1 << MaxSetBits;
    localparam int WayBits    = (Ways > 1) ? $clog2(Ways) : 1;
    localparam int WayCntBits = $clog2(Ways + 1);

    localparam logic [1:0] REG_SET_BITS = 2'd0;
    localparam logic [1:0] REG_OFF_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS     = 2'd2;
    localparam logic [1:0] REG_POLICY   = 2'd3;

    localparam logic POLICY_LRU = 1'b1;

    // classified item handed from the front to the back
    typedef struct packed {
        logic [MaxSetBits-1:0] set;
        logic [63:0]           tag;
        logic [3:0]            ways;
        logic                  lru;
    } t_req;

    typedef struct packed {
        logic                 hit;
        logic                 evict;
        logic [WayBits-1:0]   way;
    } t_res;

endpackage

### rtl/sactl_front.sv
// ----------------------------------------------------------------------------
// sactl_front
// splits an address into set and tag and queues the request (two entries)
// ----------------------------------------------------------------------------
module sactl_front
    import sactl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_access_address,
    input  logic [3:0]  i_set_index_bits,
    input  logic [5:0]  i_block_offset_bits,
    input  logic [3:0]  i_ways_in_use,
    input  logic        i_replace_policy,
    output logic        o_req_valid,
    input  logic        i_req_ready,
    output t_req        o_req
);

    t_req       r_q [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    t_req       w_req;
    logic [3:0] w_sb;
    logic [6:0] w_tsh;
    logic [63:0] w_sh;
    logic       w_push, w_pop;

    always_comb begin
        w_sb  = (i_set_index_bits > 4'(MaxSetBits)) ? 4'(MaxSetBits) : i_set_index_bits;
        w_sh  = i_access_address >> i_block_offset_bits;
        w_req.set = MaxSetBits'(w_sh) & MaxSetBits'((9'd1 << w_sb) - 9'd1);
        w_tsh = 7'(w_sb) + 7'(i_block_offset_bits);
        w_req.tag = (w_tsh >= 7'd64) ? 64'd0 : (i_access_address >> w_tsh);
        if (i_ways_in_use == 4'd0) begin
            w_req.ways = 4'd1;
        end else if (i_ways_in_use > 4'(Ways)) begin
            w_req.ways = 4'(Ways);
        end else begin
            w_req.ways = i_ways_in_use;
        end
        w_req.lru = (i_replace_policy == POLICY_LRU);
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_req_valid && i_req_ready;

    always_comb begin
        n_wp  = r_wp ^ w_push;
        n_rp  = r_rp ^ w_pop;
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_q[r_wp] <= w_req;
        end
    end

endmodule

### rtl/sactl_back.sv
// ----------------------------------------------------------------------------
// sactl_back
// reads a set, compares tags, picks a victim, writes back and holds the result
// ----------------------------------------------------------------------------
module sactl_back
    import sactl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  t_req        i_req,
    output logic        o_valid,
    input  logic        i_ready,
    output t_res        o_res,
    output logic [31:0] o_hit_total,
    output logic [31:0] o_miss_total,
    output logic [31:0] o_eviction_total
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    // tag, stamp and valid stores, one row per set holding all ways
    logic [Ways*64-1:0] r_tag_mem   [SetCount];
    logic [Ways*32-1:0] r_stamp_mem [SetCount];
    logic [Ways-1:0]    r_valid_mem [SetCount];
    logic [Ways*64-1:0] r_tag_rd;
    logic [Ways*32-1:0] r_stamp_rd;
    logic [Ways-1:0]    r_valid_rd;

    logic [1:0]  r_st, n_st;
    t_req        r_req;
    t_res        r_res;
    logic [31:0] r_ctr, r_hits, r_miss, r_evs;
    logic                  r_clr_busy;
    logic [MaxSetBits-1:0] r_clr_idx;

    logic [Ways-1:0]    w_vrow;
    logic               w_hit, w_empty;
    logic [WayBits-1:0] w_hway, w_eway, w_vway, w_used;
    logic [31:0]        w_best;
    logic               w_wr_tag, w_wr_stamp;
    logic               w_take;

    assign o_req_ready = (r_st == ST_IDLE) && !r_clr_busy;
    assign w_take      = o_req_ready && i_req_valid;
    assign o_valid     = (r_st == ST_OUT);
    assign o_res       = r_res;
    assign o_hit_total = r_hits;
    assign o_miss_total = r_miss;
    assign o_eviction_total = r_evs;
    assign w_vrow = r_valid_rd;

    always_comb begin
        w_hit   = 1'b0;
        w_empty = 1'b0;
        w_hway  = '0;
        w_eway  = '0;
        w_vway  = '0;
        w_best  = r_stamp_rd[31:0];
        for (int w = 0; w < Ways; w++) begin
            if (4'(w) < r_req.ways) begin
                if (!w_vrow[w]) begin
                    if (!w_empty && !w_hit) begin
                        w_empty = 1'b1;
                        w_eway  = WayBits'(w);
                    end
                end else if (!w_hit && r_tag_rd[w*64 +: 64] == r_req.tag) begin
                    w_hit  = 1'b1;
                    w_hway = WayBits'(w);
                end
                if (w > 0 && r_stamp_rd[w*32 +: 32] < w_best) begin
                    w_best = r_stamp_rd[w*32 +: 32];
                    w_vway = WayBits'(w);
                end
            end
        end
        w_used     = w_hit ? w_hway : (w_empty ? w_eway : w_vway);
        w_wr_tag   = (r_st == ST_LOOK) && !w_hit;
        w_wr_stamp = (r_st == ST_LOOK) && (!w_hit || r_req.lru);
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (w_take) n_st = ST_LOOK;
            ST_LOOK: n_st = ST_OUT;
            ST_OUT:  if (i_ready) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ST_IDLE;
            r_ctr      <= '0;
            r_hits     <= '0;
            r_miss     <= '0;
            r_evs      <= '0;
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else begin
            r_st <= n_st;
            // one set of valid bits cleared per cycle after reset
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == MaxSetBits'(SetCount - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (r_st == ST_LOOK) begin
                r_ctr <= r_ctr + 32'd1;
                if (w_hit) begin
                    r_hits <= r_hits + 32'd1;
                end else begin
                    r_miss <= r_miss + 32'd1;
                    if (!w_empty) begin
                        r_evs <= r_evs + 32'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req      <= i_req;
            r_tag_rd   <= r_tag_mem[i_req.set];
            r_stamp_rd <= r_stamp_mem[i_req.set];
            r_valid_rd <= r_valid_mem[i_req.set];
        end
        if (r_st == ST_LOOK) begin
            r_res.hit   <= w_hit;
            r_res.evict <= !w_hit && !w_empty;
            r_res.way   <= w_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_tag) begin
            r_tag_mem[r_req.set][w_used*64 +: 64] <= r_req.tag;
        end
        if (w_wr_stamp) begin
            r_stamp_mem[r_req.set][w_used*32 +: 32] <= r_ctr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_valid_mem[r_clr_idx] <= '0;
        end else if (w_wr_tag) begin
            r_valid_mem[r_req.set][w_used] <= 1'b1;
        end
    end

endmodule

### rtl/set_assoc_cache_tag_lookup_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_unit
// tag store of a set-associative cache with lru or fifo replacement
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// access    in         i_valid / o_ready  i_access_address
// result    out        o_valid / i_ready  o_was_hit .. o_eviction_total
// config    in         apb write          set bits, offset bits, ways, policy
//
// in the back end an item passes the set row read, then compare and victim
// pick with write back, then the result register.
// a two-entry queue lets the front take items while the back is busy.
// reset is synchronous and clears control and totals; the valid bits are then
// cleared one set per cycle over all sets, while the back takes no item.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup_unit
    import sactl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_access_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_was_hit,
    output logic        o_was_eviction,
    output logic [2:0]  o_way_used,
    output logic [31:0] o_hit_total,
    output logic [31:0] o_miss_total,
    output logic [31:0] o_eviction_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0] r_set_bits;
    logic [5:0] r_off_bits;
    logic [3:0] r_ways;
    logic       r_policy;
    logic       w_req_valid, w_req_ready, w_wr;
    t_req       w_req;
    t_res       w_res;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits <= 4'd0;
            r_off_bits <= 6'd4;
            r_ways     <= 4'd8;
            r_policy   <= 1'b1;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_SET_BITS: r_set_bits <= pwdata[3:0];
                REG_OFF_BITS: r_off_bits <= pwdata[5:0];
                REG_WAYS:     r_ways     <= pwdata[3:0];
                REG_POLICY:   r_policy   <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SET_BITS: prdata = {28'd0, r_set_bits};
            REG_OFF_BITS: prdata = {26'd0, r_off_bits};
            REG_WAYS:     prdata = {28'd0, r_ways};
            REG_POLICY:   prdata = {31'd0, r_policy};
            default:      prdata = 32'd0;
        endcase
    end

    sactl_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_access_address    (i_access_address),
        .i_set_index_bits    (r_set_bits),
        .i_block_offset_bits (r_off_bits),
        .i_ways_in_use       (r_ways),
        .i_replace_policy    (r_policy),
        .o_req_valid         (w_req_valid),
        .i_req_ready         (w_req_ready),
        .o_req               (w_req)
    );

    sactl_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (w_req_valid),
        .o_req_ready      (w_req_ready),
        .i_req            (w_req),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_res            (w_res),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total),
        .o_eviction_total (o_eviction_total)
    );

    assign o_was_hit      = w_res.hit;
    assign o_was_eviction = w_res.evict;
    assign o_way_used     = 3'(w_res.way);

`include "set_assoc_cache_tag_lookup_unit_assert.svh"

    `SACT_ASSERT(a_hit_no_evict, o_valid |-> !(o_was_hit && o_was_eviction), "hit with evict")
    `SACT_STABLE(a_out_hold, (o_valid && !i_ready), o_hit_total, "total moved")
    `SACT_STABLE(a_way_hold, (o_valid && !i_ready), o_way_used, "way moved")
    `SACT_ASSERT(a_evict_miss, (o_valid && o_was_eviction) |-> (o_miss_total != 32'd0), "evict")

endmodule
